// ===== src/tcpm_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpm_pkg: shared types and constants of the two-channel PCM/PWM mixer
// Item and result words, the configuration bundle, register map and the
// fixed-point gain table.
// ----------------------------------------------------------------------------
package tcpm_pkg;

  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_VOLUME      = 2'd0;
  localparam logic [1:0] REG_START_WAIT  = 2'd1;
  localparam logic [1:0] REG_END_WAIT    = 2'd2;

  localparam logic [3:0]  VOLUME_RST     = 4'd7;
  localparam logic [3:0]  VOLUME_MAX     = 4'd9;
  localparam logic [15:0] WAIT_RST       = 16'd1000;
  localparam logic [7:0]  DUTY_RST       = 8'h80;
  localparam logic [7:0]  OFFSET_ZERO    = 8'h80;

  // gain/100 in Q16, rounded up so that the product truncates correctly
  localparam int unsigned GainFracW = 16;
  localparam int unsigned GainW     = 17;

  typedef struct packed {
    logic [3:0]  volume_level;
    logic [15:0] speech_start_wait;
    logic [15:0] speech_end_wait;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic       main_ready;
    logic [7:0] main_byte;
    logic       speech_ready;
    logic [7:0] speech_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       main_taken;
    logic       speech_taken;
    logic       speech_active;
  } result_t;

  function automatic logic [GainW-1:0] gain_recip(input logic [3:0] idx);
    logic [GainW-1:0] r;
    case (idx)
      4'd0:    r = 17'd3277;   // 5%
      4'd1:    r = 17'd6554;   // 10%
      4'd2:    r = 17'd9831;   // 15%
      4'd3:    r = 17'd13108;  // 20%
      4'd4:    r = 17'd19661;  // 30%
      4'd5:    r = 17'd32768;  // 50%
      4'd6:    r = 17'd49152;  // 75%
      4'd7:    r = 17'd65536;  // 100%
      4'd8:    r = 17'd81920;  // 125%
      default: r = 17'd98304;  // 150%
    endcase
    return r;
  endfunction

endpackage

// ===== src/tcpm_in_if.sv =====
// ----------------------------------------------------------------------------
// tcpm_in_if: tick channel into the mixer
// Valid/ready channel carrying one tick word with both queue heads.
// ----------------------------------------------------------------------------
interface tcpm_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic       main_ready;
  logic [7:0] main_byte;
  logic       speech_ready;
  logic [7:0] speech_byte;

  modport source (output valid, mode, main_ready, main_byte, speech_ready, speech_byte,
                  input ready);
  modport sink   (input valid, mode, main_ready, main_byte, speech_ready, speech_byte,
                  output ready);
endinterface

// ===== src/tcpm_out_if.sv =====
// ----------------------------------------------------------------------------
// tcpm_out_if: result channel out of the mixer
// Valid/ready channel carrying the duty value and the queue pop flags.
// ----------------------------------------------------------------------------
interface tcpm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty;
  logic       main_taken;
  logic       speech_taken;
  logic       speech_active;

  modport source (output valid, duty, main_taken, speech_taken, speech_active,
                  input ready);
  modport sink   (input valid, duty, main_taken, speech_taken, speech_active,
                  output ready);
endinterface

// ===== src/tcpm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tcpm_cfg_regs: APB configuration registers
// Volume index and the speech start/end wait counts.
// ----------------------------------------------------------------------------
module tcpm_cfg_regs
  import tcpm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volume_level      <= VOLUME_RST;
      cfg_q.speech_start_wait <= WAIT_RST;
      cfg_q.speech_end_wait   <= WAIT_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_VOLUME:     cfg_q.volume_level      <= pwdata[3:0];
        REG_START_WAIT: cfg_q.speech_start_wait <= pwdata[15:0];
        REG_END_WAIT:   cfg_q.speech_end_wait   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_VOLUME:     prdata = {28'd0, cfg_q.volume_level};
      REG_START_WAIT: prdata = {16'd0, cfg_q.speech_start_wait};
      REG_END_WAIT:   prdata = {16'd0, cfg_q.speech_end_wait};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/tcpm_mix_core.sv =====
// ----------------------------------------------------------------------------
// tcpm_mix_core: channel state and single-pass mix
// Holds both sample levels, the speech hysteresis and the held duty, and
// computes one result word per step from the registered tick word.
// ----------------------------------------------------------------------------
module tcpm_mix_core
  import tcpm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  input  logic    step_i,
  output result_t res_o
);

  logic signed [7:0] main_level_q, main_level_d;
  logic signed [7:0] speech_level_q, speech_level_d;
  logic              waiting_q, waiting_d;
  logic [15:0]       wait_cnt_q, wait_cnt_d;
  logic [7:0]        duty_q, duty_d;

  logic [15:0]       wait_inc;
  logic [3:0]        vol_idx;
  logic [7:0]        main_mag;
  logic [GainW+7:0]  prod;
  logic [8:0]        scaled_mag;
  logic signed [9:0] scaled;
  logic signed [9:0] sum;
  logic signed [7:0] clamped;
  logic              main_taken, speech_taken;

  function automatic logic signed [7:0] decay(input logic signed [7:0] v);
    logic signed [7:0] r;
    if (v > 0)      r = v - 8'sd1;
    else if (v < 0) r = v + 8'sd1;
    else            r = v;
    return r;
  endfunction

  assign wait_inc = wait_cnt_q + 16'd1;
  assign vol_idx  = (cfg_i.volume_level > VOLUME_MAX) ? VOLUME_MAX : cfg_i.volume_level;

  // main channel: new sample or decay, then gain with truncation toward zero
  always_comb begin
    main_taken = 1'b0;
    if (item_i.main_ready) begin
      main_level_d = $signed(item_i.main_byte ^ OFFSET_ZERO);
      main_taken   = 1'b1;
    end else begin
      main_level_d = decay(main_level_q);
    end
  end

  assign main_mag   = main_level_d[7] ? 8'(-main_level_d) : 8'(main_level_d);
  assign prod       = {{GainW{1'b0}}, main_mag} * {8'd0, gain_recip(vol_idx)};
  assign scaled_mag = prod[GainFracW +: 9];
  assign scaled     = main_level_d[7] ? -$signed({1'b0, scaled_mag})
                                      : $signed({1'b0, scaled_mag});
  assign sum        = scaled + 10'(speech_level_q);

  always_comb begin
    if (sum < -10'sd128)     clamped = -8'sd128;
    else if (sum > 10'sd127) clamped = 8'sd127;
    else                     clamped = sum[7:0];
  end

  // speech channel hysteresis
  always_comb begin
    speech_level_d = speech_level_q;
    waiting_d      = waiting_q;
    wait_cnt_d     = wait_cnt_q;
    speech_taken   = 1'b0;
    if (!item_i.speech_ready) begin
      speech_level_d = decay(speech_level_q);
      if (waiting_q) begin
        wait_cnt_d = '0;
      end else begin
        wait_cnt_d = wait_inc;
        if (wait_inc >= cfg_i.speech_end_wait) waiting_d = 1'b1;
      end
    end else if (!waiting_q) begin
      speech_level_d = $signed(item_i.speech_byte ^ OFFSET_ZERO);
      speech_taken   = 1'b1;
      wait_cnt_d     = '0;
    end else begin
      wait_cnt_d = wait_inc;
      if (wait_inc >= cfg_i.speech_start_wait) waiting_d = 1'b0;
    end
  end

  assign duty_d = clamped ^ OFFSET_ZERO;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_level_q   <= '0;
      speech_level_q <= '0;
      waiting_q      <= 1'b1;
      wait_cnt_q     <= '0;
      duty_q         <= DUTY_RST;
    end else if (step_i) begin
      if (item_i.mode) begin
        speech_level_q <= speech_level_d;
        waiting_q      <= waiting_d;
        wait_cnt_q     <= wait_cnt_d;
      end else begin
        main_level_q <= main_level_d;
        duty_q       <= duty_d;
      end
    end
  end

  always_comb begin
    if (item_i.mode) begin
      res_o.duty          = duty_q;
      res_o.main_taken    = 1'b0;
      res_o.speech_taken  = speech_taken;
      res_o.speech_active = ~waiting_d;
    end else begin
      res_o.duty          = duty_d;
      res_o.main_taken    = main_taken;
      res_o.speech_taken  = 1'b0;
      res_o.speech_active = ~waiting_q;
    end
  end

endmodule

// ===== src/two_channel_pcm_pwm_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// two_channel_pcm_pwm_mixer_unit: two-channel PCM to PWM duty mixer
// Usage notes:
//   in_i  carries one tick word per handshake: mode (0 main, 1 speech) plus
//         the head byte and ready flag of the main and speech queues.
//   out_o returns one word per tick: the PWM duty, the two pop flags that
//         tell the queues whether their head byte was consumed, and whether
//         speech is playing.
//   APB   volume index (0x0), speech start wait (0x4), speech end wait (0x8);
//         write only while no tick is in flight.
// A tick word is registered on acceptance, mixed in one pass from the
// input register and lands in the output register once that slot is free,
// where it is offered. One tick per cycle is sustained while the receiver
// keeps ready high; the rate is set by the combinational mix path (one 8x17
// multiply, add and clamp) between the input and output registers.
// If the receiver stalls, the output word holds and the input register
// keeps taking one more word; ready drops only when both are full.
// Reset empties both registers, zeroes the sample levels, puts speech in
// the waiting state and sets the duty to mid scale (0x80).
// ----------------------------------------------------------------------------
module two_channel_pcm_pwm_mixer_unit
  import tcpm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  tcpm_in_if.sink             in_i,
  tcpm_out_if.source          out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid_q;
  result_t res, res_q;
  logic    res_valid_q;
  logic    advance;

  tcpm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // advance the registered word into the output slot when it is free
  assign advance  = item_valid_q & (~res_valid_q | out_o.ready);
  assign in_i.ready = ~item_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.mode         <= in_i.mode;
      item_q.main_ready   <= in_i.main_ready;
      item_q.main_byte    <= in_i.main_byte;
      item_q.speech_ready <= in_i.speech_ready;
      item_q.speech_byte  <= in_i.speech_byte;
    end
  end

  tcpm_mix_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (item_q),
    .step_i (advance),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid         = res_valid_q;
  assign out_o.duty          = res_q.duty;
  assign out_o.main_taken    = res_q.main_taken;
  assign out_o.speech_taken  = res_q.speech_taken;
  assign out_o.speech_active = res_q.speech_active;

endmodule
